// ----- hdl/tnc_pkg.sv -----
// shared types, constants and a helper function of the timestamp nibble record block
`default_nettype none
package tnc_pkg;

  localparam int TIME_NIBBLES = 13;
  localparam int CRC_NIBBLES  = 4;
  localparam int TICK_W       = 4 * TIME_NIBBLES;
  localparam int RECORD_LEN   = 2 * TIME_NIBBLES + CRC_NIBBLES + 1;
  localparam int STEP_W       = $clog2(RECORD_LEN);
  localparam int ADDR_W       = 7;

  localparam int SECS_W       = 32;
  localparam int USEC_W       = 20;
  localparam int USEC_SHIFT   = 7;
  localparam int USEC_X_W     = USEC_W + USEC_SHIFT;
  localparam int RECIP_SHIFT  = 32;
  localparam int FRAC_W       = 14;
  localparam int REM_W        = 15;
  localparam int TICK_SHIFT   = 13;

  localparam logic [USEC_X_W-1:0] USEC_DIVISOR = USEC_X_W'(15625);
  localparam logic [USEC_X_W-1:0] USEC_RECIP   =
    USEC_X_W'((64'd1 << RECIP_SHIFT) / 64'd15625);

  localparam logic [TICK_W-1:0] EPOCH_TICKS  = TICK_W'(64'h1CF2E8F800000);
  localparam logic [TICK_W-1:0] TIMEOUT_SPAN = TICK_W'(64'h00b40000);
  localparam logic [15:0]       CRC_POLY     = 16'h1081;

  localparam logic [ADDR_W-1:0] ADDR_TIME_SX    = 7'h52;
  localparam logic [ADDR_W-1:0] ADDR_CRC_SX     = 7'h5F;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT_SX = 7'h63;
  localparam logic [ADDR_W-1:0] ADDR_FLAG_SX    = 7'h70;
  localparam logic [ADDR_W-1:0] ADDR_TIME_GX    = 7'h58;
  localparam logic [ADDR_W-1:0] ADDR_CRC_GX     = 7'h65;
  localparam logic [ADDR_W-1:0] ADDR_TIMEOUT_GX = 7'h69;
  localparam logic [ADDR_W-1:0] ADDR_FLAG_GX    = 7'h76;
  localparam logic [3:0]        FLAG_VALUE      = 4'hF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 52;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODEL_GX    = 2'd0,
    CFG_USER_OFFSET = 2'd1,
    CFG_SAVED_TIMER = 2'd2,
    CFG_ZONE_OFFSET = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [SECS_W-1:0] host_seconds;
    logic [USEC_W-1:0] host_microseconds;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] nibble_address;
    logic [3:0]        nibble_value;
    logic              last_write;
  } out_item_t;

  typedef struct packed {
    logic        model_gx;
    logic [51:0] user_offset_ticks;
    logic [31:0] saved_timer_ticks;
    logic [17:0] zone_offset_seconds;
  } cfg_t;

  // one reflected crc step over a nibble; the poly product never overlaps
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [3:0] nib);
    logic [3:0]  t;
    logic [15:0] prod;
    t    = crc[3:0] ^ nib;
    prod = ({12'd0, t} << 12) | ({12'd0, t} << 7) | {12'd0, t};
    prod = prod & {16{|CRC_POLY}};
    return (crc >> 4) ^ prod;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/timestamp_nibble_crc_record.sv -----
// Converts a host time (seconds, microseconds) into an 8192 Hz tick count and
// emits a 31-item record of nibble writes: 13 tick nibbles low first, a 4-nibble
// reflected CRC-16 over them, 13 nibbles of ticks plus the timeout span, and a
// 0xF flag marked by last_write. A four-stage front pipeline does the arithmetic
// and feeds a two-entry queue; the back sequencer drives one nibble write per
// cycle while the receiver does not stall it, and records follow each other
// without a gap while the queue holds tick counts. Configuration writes are
// always taken (ready stays high).
`default_nettype none
module timestamp_nibble_crc_record (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire tnc_pkg::in_item_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output tnc_pkg::out_item_t                  out_data_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [tnc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [tnc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import tnc_pkg::*;

  cfg_t              cfg_q;
  logic              q_full, q_push, q_valid, q_pop;
  logic [TICK_W-1:0] q_in, q_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODEL_GX:    cfg_q.model_gx            <= cfg_data_i[0];
        CFG_USER_OFFSET: cfg_q.user_offset_ticks   <= cfg_data_i[51:0];
        CFG_SAVED_TIMER: cfg_q.saved_timer_ticks   <= cfg_data_i[31:0];
        CFG_ZONE_OFFSET: cfg_q.zone_offset_seconds <= cfg_data_i[17:0];
        default: ;
      endcase
    end
  end

  tnc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  tnc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_out)
  );

  tnc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .model_gx_i  (cfg_q.model_gx),
    .q_valid_i   (q_valid),
    .q_data_i    (q_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

// ----- hdl/tnc_front.sv -----
// front pipeline: converts host time to an 8192 hz tick count
`default_nettype none
module tnc_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire tnc_pkg::in_item_t           in_data_i,
  input  wire tnc_pkg::cfg_t               cfg_i,
  input  wire logic                        q_full_i,
  output logic                             q_push_o,
  output logic [tnc_pkg::TICK_W-1:0]       q_data_o
);
  import tnc_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q;
  logic en;

  logic [FRAC_W-1:0]   q0_1_q, q0_2_q;
  logic [USEC_X_W-1:0] x1_q;
  logic [TICK_W-1:0]   secs1_q, usr1_q;
  logic [REM_W-1:0]    rem2_q;
  logic [TICK_W-1:0]   sa2_q, sb3_q, ticks4_q;
  logic [FRAC_W-1:0]   frac3_q;

  logic [USEC_X_W-1:0]   x_d;
  logic [2*USEC_X_W-1:0] prod_d;
  logic [USEC_X_W:0]     qmul_d;
  logic [USEC_X_W:0]     rem_d;

  assign en         = !(v4_q && q_full_i);
  assign in_stall_o = !en;
  assign q_push_o   = v4_q && !q_full_i;
  assign q_data_o   = ticks4_q;

  assign x_d    = {in_data_i.host_microseconds, USEC_SHIFT'(0)};
  assign prod_d = (2*USEC_X_W)'(x_d) * (2*USEC_X_W)'(USEC_RECIP);
  assign qmul_d = (USEC_X_W+1)'(q0_1_q) * (USEC_X_W+1)'(USEC_DIVISOR);
  assign rem_d  = (USEC_X_W+1)'(x1_q) - qmul_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // stage 1: reciprocal multiply, zone and offset adjust
      x1_q    <= x_d;
      q0_1_q  <= prod_d[RECIP_SHIFT +: FRAC_W];
      secs1_q <= TICK_W'(in_data_i.host_seconds)
                 - TICK_W'(signed'(cfg_i.zone_offset_seconds));
      usr1_q  <= TICK_W'(signed'(cfg_i.user_offset_ticks))
                 + TICK_W'(signed'(cfg_i.saved_timer_ticks));
      // stage 2: remainder of the estimate
      q0_2_q  <= q0_1_q;
      rem2_q  <= rem_d[REM_W-1:0];
      sa2_q   <= (secs1_q << TICK_SHIFT) + usr1_q;
      // stage 3: estimate is at most one low
      frac3_q <= q0_2_q + FRAC_W'(rem2_q >= REM_W'(USEC_DIVISOR));
      sb3_q   <= sa2_q + EPOCH_TICKS;
      // stage 4
      ticks4_q <= sb3_q + TICK_W'(frac3_q);
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tnc_queue.sv -----
// short queue of tick counts between front and back
`default_nettype none
module tnc_queue (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push_i,
  input  wire logic [tnc_pkg::TICK_W-1:0]  push_data_i,
  output logic                             full_o,
  input  wire logic                        pop_i,
  output logic                             valid_o,
  output logic [tnc_pkg::TICK_W-1:0]       pop_data_o
);
  import tnc_pkg::*;

  logic [TICK_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;
  logic              do_push, do_pop;

  assign full_o     = cnt_q == (QPTR_W+1)'(QUEUE_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tnc_back.sv -----
// back sequencer: emits the nibble writes of one record per tick count
`default_nettype none
module tnc_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        model_gx_i,
  input  wire logic                        q_valid_i,
  input  wire logic [tnc_pkg::TICK_W-1:0]  q_data_i,
  output logic                             q_pop_o,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output tnc_pkg::out_item_t               out_data_o
);
  import tnc_pkg::*;

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [TICK_W-1:0] tick_sh_q, tmo_sh_q;
  logic [15:0]       crc_q;
  logic              out_valid_q;
  out_item_t         out_q;

  logic      out_free, at_last, load, advance;
  logic      ph_time, ph_crc, ph_tmo;
  out_item_t item_d;

  assign out_free = !out_valid_q || !out_stall_i;
  assign at_last  = step_q == STEP_W'(RECORD_LEN-1);
  assign advance  = busy_q && out_free;
  assign load     = q_valid_i && (!busy_q || (advance && at_last));
  assign q_pop_o  = load;

  assign ph_time = step_q < STEP_W'(TIME_NIBBLES);
  assign ph_crc  = step_q < STEP_W'(TIME_NIBBLES + CRC_NIBBLES);
  assign ph_tmo  = step_q < STEP_W'(2*TIME_NIBBLES + CRC_NIBBLES);

  always_comb begin
    item_d.last_write = 1'b0;
    if (ph_time) begin
      item_d.nibble_address = (model_gx_i ? ADDR_TIME_GX : ADDR_TIME_SX) + ADDR_W'(step_q);
      item_d.nibble_value   = tick_sh_q[3:0];
    end else if (ph_crc) begin
      item_d.nibble_address = (model_gx_i ? ADDR_CRC_GX : ADDR_CRC_SX) + ADDR_W'(step_q)
                              - ADDR_W'(TIME_NIBBLES);
      item_d.nibble_value   = crc_q[3:0];
    end else if (ph_tmo) begin
      item_d.nibble_address = (model_gx_i ? ADDR_TIMEOUT_GX : ADDR_TIMEOUT_SX)
                              + ADDR_W'(step_q) - ADDR_W'(TIME_NIBBLES + CRC_NIBBLES);
      item_d.nibble_value   = tmo_sh_q[3:0];
    end else begin
      item_d.nibble_address = model_gx_i ? ADDR_FLAG_GX : ADDR_FLAG_SX;
      item_d.nibble_value   = FLAG_VALUE;
      item_d.last_write     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (advance) begin
        busy_q <= !at_last;
        step_q <= step_q + 1'b1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= item_d;
    end
    if (load) begin
      tick_sh_q <= q_data_i;
      tmo_sh_q  <= q_data_i + TIMEOUT_SPAN;
      crc_q     <= '0;
    end else if (advance) begin
      if (ph_time) begin
        tick_sh_q <= tick_sh_q >> 4;
        crc_q     <= crc_step(crc_q, tick_sh_q[3:0]);
      end else if (ph_crc) begin
        crc_q <= crc_q >> 4;
      end else if (ph_tmo) begin
        tmo_sh_q <= tmo_sh_q >> 4;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ----- tb/tb_timestamp_nibble_crc_record.sv -----
// testbench of the timestamp nibble record block: directed and random times checked per write
`timescale 1ns / 100ps
`default_nettype none
module tb_timestamp_nibble_crc_record;
  import tnc_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          SETTLE       = 20;
  localparam int          SHOWN_ERRORS = 10;
  localparam int          TIME_NIBS    = 13;
  localparam int          CRC_NIBS     = 4;
  localparam logic [63:0] EPOCH        = 64'h1CF2E8F800000;
  localparam logic [63:0] SPAN         = 64'h00b40000;
  localparam logic [15:0] POLY         = 16'h1081;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  in_item_t              in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  out_item_t             out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // shadow copy of the block's registers
  logic        gx_sel;
  logic [51:0] user_ticks;
  logic [31:0] saved_ticks;
  logic [17:0] zone_secs;

  out_item_t expected_writes[$];
  int        mismatches;
  int        cycles;
  int        burst_left;

  timestamp_nibble_crc_record i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver stall pattern: free, half random, periodic, mostly stalled
  int stall_count;
  always @(negedge clk_i) begin
    stall_count <= stall_count + 1;
    case ((stall_count / 97) % 4)
      0: begin
        out_stall_i <= 1'b0;
      end
      1: begin
        out_stall_i <= $urandom_range(0, 1);
      end
      2: begin
        out_stall_i <= (stall_count % 5) < 2;
      end
      default: begin
        out_stall_i <= $urandom_range(0, 9) < 8;
      end
    endcase
  end

  function automatic logic [63:0] sext(input logic [63:0] v, input int width);
    logic [63:0] mask;
    mask = (64'd1 << width) - 64'd1;
    v    = v & mask;
    if (v[width-1]) begin
      v = v | ~mask;
    end
    return v;
  endfunction

  // tick count, its crc, the timeout copy and the closing flag as the sequence of nibble writes
  function automatic void predict_record(input in_item_t it);
    logic [63:0] ticks;
    logic [63:0] timeout;
    logic [63:0] frac;
    logic [15:0] crc;
    logic [3:0]  nib;
    logic [6:0]  time_base;
    logic [6:0]  crc_base;
    logic [6:0]  timeout_base;
    logic [6:0]  flag_addr;
    out_item_t   w;
    time_base    = gx_sel ? 7'h58 : 7'h52;
    crc_base     = gx_sel ? 7'h65 : 7'h5F;
    timeout_base = gx_sel ? 7'h69 : 7'h63;
    flag_addr    = gx_sel ? 7'h76 : 7'h70;
    ticks   = {32'd0, it.host_seconds} - sext({46'd0, zone_secs}, 18);
    ticks   = ticks << 13;
    frac    = ({44'd0, it.host_microseconds} * 64'd128) / 64'd15625;
    ticks   = ticks + frac + EPOCH + sext({12'd0, user_ticks}, 52)
              + sext({32'd0, saved_ticks}, 32);
    timeout = ticks + SPAN;
    crc     = 16'd0;
    for (int i = 0; i < TIME_NIBS; i++) begin
      nib = ticks[4*i +: 4];
      crc = (crc >> 4) ^ (16'({12'd0, crc[3:0] ^ nib}) * POLY);
      w.nibble_address = time_base + 7'(i);
      w.nibble_value   = nib;
      w.last_write     = 1'b0;
      expected_writes.push_back(w);
    end
    for (int i = 0; i < CRC_NIBS; i++) begin
      w.nibble_address = crc_base + 7'(i);
      w.nibble_value   = crc[4*i +: 4];
      w.last_write     = 1'b0;
      expected_writes.push_back(w);
    end
    for (int i = 0; i < TIME_NIBS; i++) begin
      w.nibble_address = timeout_base + 7'(i);
      w.nibble_value   = timeout[4*i +: 4];
      w.last_write     = 1'b0;
      expected_writes.push_back(w);
    end
    w.nibble_address = flag_addr;
    w.nibble_value   = 4'hF;
    w.last_write     = 1'b1;
    expected_writes.push_back(w);
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) begin
      $display("%0t: %s", $realtime, what);
    end
  endtask

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write addr %h value %h last %b",
                                out_data_o.nibble_address, out_data_o.nibble_value,
                                out_data_o.last_write));
      end else begin
        want = expected_writes.pop_front();
        if (out_data_o.nibble_address !== want.nibble_address ||
            out_data_o.nibble_value !== want.nibble_value ||
            out_data_o.last_write !== want.last_write) begin
          note_mismatch($sformatf(
            "expected addr %h value %h last %b, got addr %h value %h last %b",
            want.nibble_address, want.nibble_value, want.last_write,
            out_data_o.nibble_address, out_data_o.nibble_value, out_data_o.last_write));
        end
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [51:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MODEL_GX:    gx_sel      = data[0];
      CFG_USER_OFFSET: user_ticks  = data;
      CFG_SAVED_TIMER: saved_ticks = data[31:0];
      CFG_ZONE_OFFSET: zone_secs   = data[17:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic gx, input logic [51:0] user,
                           input logic [51:0] saved, input logic [51:0] zone);
    write_reg(CFG_MODEL_GX, {51'd0, gx});
    write_reg(CFG_USER_OFFSET, user);
    write_reg(CFG_SAVED_TIMER, saved);
    write_reg(CFG_ZONE_OFFSET, zone);
  endtask

  // sender bursts: valid stays high inside a burst, drops for a random gap between
  task automatic send_time(input logic [31:0] secs, input logic [19:0] usec);
    in_item_t it;
    it.host_seconds      = secs;
    it.host_microseconds = usec;
    if (burst_left == 0) begin
      if (in_valid_i) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      repeat ($urandom_range(0, 7)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 50)
                                               : $urandom_range(1, 6);
    end
    @(negedge clk_i);
    in_data_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_record(it);
    burst_left--;
  endtask

  task automatic drain();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    burst_left = 0;
    while (expected_writes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic test_reset_values();
    send_time(32'd0, 20'd0);
    send_time(32'd1700000000, 20'd500000);
    drain();
  endtask

  task automatic test_field_extremes();
    send_time(32'hFFFFFFFF, 20'd999999);
    send_time(32'hAAAAAAAA, 20'h55555);
    send_time(32'h55555555, 20'hAAAAA);
    // microseconds past one second are used as given
    send_time(32'd12345, 20'd1000000);
    send_time(32'd0, 20'hFFFFF);
    send_time(32'd86400, 20'd122);
    drain();
  endtask

  task automatic test_model_addresses();
    write_reg(CFG_MODEL_GX, 52'h1);
    send_time(32'h12345678, 20'd250000);
    send_time(32'hFFFFFFFF, 20'hFFFFF);
    drain();
    // upper data bits are ignored by the one-bit register
    write_reg(CFG_MODEL_GX, 52'hFFFFFFFFFFFFE);
    send_time(32'h12345678, 20'd250000);
    drain();
  endtask

  task automatic test_register_extremes();
    write_all(1'b1, 52'h7FFFFFFFFFFFF, 52'h7FFFFFFF, 52'(86400));
    send_time(32'hFFFFFFFF, 20'd999999);
    send_time(32'd0, 20'd0);
    drain();
    // negative sums wrap below zero
    write_all(1'b0, 52'h8000000000000, 52'h80000000, 52'(-86400));
    send_time(32'd0, 20'd0);
    send_time(32'hFFFFFFFF, 20'hFFFFF);
    drain();
    // zone offsets outside a day are taken as two's complement
    write_all(1'b1, 52'hFFFFFFFFFFFFF, 52'hFFFFFFFF, 52'h1FFFF);
    send_time(32'h80000000, 20'd1);
    drain();
    write_reg(CFG_ZONE_OFFSET, 52'h20000);
    send_time(32'h7FFFFFFF, 20'd15624);
    drain();
  endtask

  task automatic test_random_times();
    logic [51:0] user;
    logic [51:0] zone;
    for (int phase = 0; phase < 6; phase++) begin
      user = ($urandom_range(0, 1) == 0) ? 52'({$urandom, $urandom})
                                          : 52'($signed($urandom_range(0, 2000000)) - 1000000);
      zone = ($urandom_range(0, 3) == 0) ? 52'($urandom)
                                          : 52'($signed($urandom_range(0, 172800)) - 86400);
      write_all(1'($urandom_range(0, 1)), user, 52'({$urandom, $urandom}), zone);
      for (int n = 0; n < 30; n++) begin
        send_time($urandom,
                  ($urandom_range(0, 7) == 0) ? 20'($urandom) : 20'($urandom_range(0, 999999)));
      end
      drain();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    gx_sel      = 1'b0;
    user_ticks  = '0;
    saved_ticks = '0;
    zone_secs   = '0;
    mismatches  = 0;
    cycles      = 0;
    stall_count = 0;
    burst_left  = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    test_reset_values();
    test_field_extremes();
    test_model_addresses();
    test_register_extremes();
    test_random_times();

    drain();
    if (expected_writes.size() != 0) begin
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
hdl/tnc_pkg.sv
hdl/tnc_front.sv
hdl/tnc_queue.sv
hdl/tnc_back.sv
hdl/timestamp_nibble_crc_record.sv
tb/tb_timestamp_nibble_crc_record.sv
